[rtl/jse_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// jse_pkg
// Types, character constants and escape helpers for the JSON string escaper.
// -----------------------------------------------------------------------------
package jse_pkg;

	localparam int JOB_BYTES = 8;
	localparam int ESC_BYTES = 6;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_END  = 1'b1
	} op_t;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_EIGHT = 8'h38;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6e;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CTRL_MAX = 8'h1f;
	localparam logic [7:0] LS_LEAD  = 8'he2;
	localparam logic [7:0] LS_MID   = 8'h80;
	localparam logic [7:0] LS_2028  = 8'ha8;
	localparam logic [7:0] LS_2029  = 8'ha9;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_done;
	} out_item_t;

	// one accepted item worth of output bytes, first byte in bytes[0]
	typedef struct packed {
		logic [JOB_BYTES-1:0][7:0] bytes;
		logic [3:0]                count;
		logic                      done;
	} job_t;

	typedef struct packed {
		logic [ESC_BYTES-1:0][7:0] b;
		logic [2:0]                len;
	} esc_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		logic [7:0] r;
		if (v < 4'd10)
			r = {4'h0, v} + 8'h30;
		else
			r = {4'h0, v} + 8'h57;
		return r;
	endfunction

	// escape sequence for a single byte with nothing held; len 0 = pass through
	function automatic esc_t escape_byte(input logic [7:0] b);
		esc_t e;
		e     = '0;
		e.b[0] = CH_BSL;
		unique case (b)
			CH_BSL:   begin e.len = 3'd2; e.b[1] = CH_BSL;   end
			CH_QUOTE: begin e.len = 3'd2; e.b[1] = CH_QUOTE; end
			8'h08:    begin e.len = 3'd2; e.b[1] = CH_B;     end
			8'h0c:    begin e.len = 3'd2; e.b[1] = CH_F;     end
			8'h0a:    begin e.len = 3'd2; e.b[1] = CH_N;     end
			8'h0d:    begin e.len = 3'd2; e.b[1] = CH_R;     end
			8'h09:    begin e.len = 3'd2; e.b[1] = CH_T;     end
			default: begin
				if (b <= CTRL_MAX) begin
					e.len  = 3'd6;
					e.b[1] = CH_U;
					e.b[2] = CH_ZERO;
					e.b[3] = CH_ZERO;
					e.b[4] = hex_digit(b[7:4]);
					e.b[5] = hex_digit(b[3:0]);
				end
			end
		endcase
		return e;
	endfunction

endpackage

[rtl/json_string_escaper.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// json_string_escaper
// Streams raw string bytes out as a quoted, escaped JSON string literal.
// An accepted item is queued as a job; its first byte then leaves through the
// emitter's output register. Throughput: one byte per cycle unless stalled;
// an item producing n bytes holds the emitter for all n, so plain text runs at
// one item per cycle and escapes hold input back through the two-entry queue.
// Reset: arst_n clears string/prefix state, the queue and the output valid.
// -----------------------------------------------------------------------------
module json_string_escaper (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               raw_valid,
	output logic               raw_stall,
	input  jse_pkg::in_item_t  raw,
	output logic               esc_valid,
	input  logic               esc_stall,
	output jse_pkg::out_item_t esc
);
	import jse_pkg::*;

	logic  accept;
	logic  job_valid;
	job_t  job;
	logic  q_full;
	logic  head_valid;
	job_t  head;
	logic  pop;

	assign raw_stall = q_full;
	assign accept    = raw_valid && !q_full;

	jse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (raw),
		.job_valid (job_valid),
		.job       (job)
	);

	jse_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_valid),
		.push_job   (job),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	jse_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (esc_valid),
		.out_stall  (esc_stall),
		.out_item   (esc)
	);

endmodule

[rtl/jse_front.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// jse_front
// Tracks string and line-separator prefix state and turns each item into a job.
// -----------------------------------------------------------------------------
module jse_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  jse_pkg::in_item_t item,
	output logic             job_valid,
	output jse_pkg::job_t    job
);
	import jse_pkg::*;

	logic       inside_q;
	logic [1:0] held_q;
	logic       inside_d;
	logic [1:0] held_d;

	logic       open_f;
	logic       close_f;
	logic [1:0] flush_n;
	esc_t       main;
	esc_t       esc;
	logic [3:0] off1, off2, off3, tot;
	logic [3:0] kk;
	logic [2:0] mi;

	assign esc = escape_byte(item.data_byte);

	always_comb begin
		inside_d = inside_q;
		held_d   = held_q;
		open_f   = !inside_q;
		close_f  = 1'b0;
		flush_n  = 2'd0;
		main     = '0;
		if (!inside_q)
			inside_d = 1'b1;
		if (item.op == OP_END) begin
			flush_n  = (held_q == 2'd0) ? 2'd0 : ((held_q == 2'd1) ? 2'd1 : 2'd2);
			held_d   = 2'd0;
			close_f  = 1'b1;
			inside_d = 1'b0;
		end else if (held_q == 2'd1 && item.data_byte == LS_MID) begin
			held_d = 2'd2;
		end else if (held_q[1] && (item.data_byte == LS_2028 ||
		                           item.data_byte == LS_2029)) begin
			held_d = 2'd0;
			main.len  = 3'd6;
			main.b[0] = CH_BSL;
			main.b[1] = CH_U;
			main.b[2] = CH_TWO;
			main.b[3] = CH_ZERO;
			main.b[4] = CH_TWO;
			main.b[5] = (item.data_byte == LS_2028) ? CH_EIGHT : CH_NINE;
		end else begin
			// broken prefix goes out literally, then the byte as if nothing held
			flush_n = (held_q == 2'd0) ? 2'd0 : ((held_q == 2'd1) ? 2'd1 : 2'd2);
			held_d  = 2'd0;
			if (item.data_byte == LS_LEAD)
				held_d = 2'd1;
			else if (esc.len != 3'd0)
				main = esc;
			else begin
				main.len  = 3'd1;
				main.b[0] = item.data_byte;
			end
		end
	end

	always_comb begin
		off1 = {3'd0, open_f};
		off2 = off1 + {2'd0, flush_n};
		off3 = off2 + {1'b0, main.len};
		tot  = off3 + {3'd0, close_f};
		job  = '0;
		job.count = (tot > 4'(JOB_BYTES)) ? 4'(JOB_BYTES) : tot;
		job.done  = close_f;
		for (int k = 0; k < JOB_BYTES; k++) begin
			kk = 4'(k);
			mi = 3'(kk - off2);
			if (kk < off1)
				job.bytes[k] = CH_QUOTE;
			else if (kk < off2)
				job.bytes[k] = (kk == off1) ? LS_LEAD : LS_MID;
			else if (kk < off3)
				job.bytes[k] = main.b[mi];
			else
				job.bytes[k] = CH_QUOTE;
		end
	end

	// an item that only extends a hold makes no job
	assign job_valid = accept && (job.count != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			held_q   <= 2'd0;
		end else if (accept) begin
			inside_q <= inside_d;
			held_q   <= held_d;
		end
	end

endmodule

[rtl/jse_queue.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// jse_queue
// Two-entry job queue between the classifier and the byte emitter.
// -----------------------------------------------------------------------------
module jse_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  jse_pkg::job_t push_job,
	input  logic          pop,
	output logic          full,
	output logic          head_valid,
	output jse_pkg::job_t head
);
	import jse_pkg::*;

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

[rtl/jse_emit.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// jse_emit
// Steps the head job into the output register a byte per cycle unless stalled.
// -----------------------------------------------------------------------------
module jse_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  jse_pkg::job_t      head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output jse_pkg::out_item_t out_item
);
	import jse_pkg::*;

	logic [2:0] idx_q;
	logic       out_valid_q;
	out_item_t  out_q;
	logic       load;
	logic       last;

	assign load      = !out_valid_q || !out_stall;
	assign last      = ({1'b0, idx_q} + 4'd1) >= head.count;
	assign pop       = load && head_valid && last;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			out_q.out_byte    <= head.bytes[idx_q];
			out_q.run_last    <= last;
			out_q.string_done <= head.done && last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid)
				idx_q <= last ? 3'd0 : idx_q + 3'd1;
		end
	end

endmodule

[dv/json_string_escaper_test.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// json_string_escaper_test
// Self-checking bench for the JSON string escaper. Raw bytes and end-of-string
// items go in with bursty pacing. The receiver stalls in runs and once holds
// off for a long stretch. A local predictor builds the expected escaped text,
// and every output item is checked against it in order.
// -----------------------------------------------------------------------------
module json_string_escaper_test;
	import jse_pkg::*;

	localparam int ITEM_TARGET = 370;
	localparam int HOLD_CYCLES = 200;
	localparam int IDLE_LIMIT  = 4000;
	localparam int TAIL_CYCLES = 20;
	localparam int MAX_REPORTS = 50;

	localparam logic [7:0] CH_BS       = 8'h08;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_LF       = 8'h0a;
	localparam logic [7:0] CH_FF       = 8'h0c;
	localparam logic [7:0] CH_CR       = 8'h0d;
	localparam logic [7:0] CH_LOWER_A  = 8'h61;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_CHOPPY,
		RX_HEAVY
	} rx_mode_t;

	logic       clk;
	logic       arst_n;
	logic       raw_valid;
	logic       raw_stall;
	in_item_t   raw;
	logic       esc_valid;
	logic       esc_stall;
	out_item_t  esc;

	// predictor state
	logic       in_string;
	logic [1:0] held_count;
	out_item_t  item_text[$];
	out_item_t  expected_text[$];

	int         items_sent;
	int         strings_sent;
	int         bytes_checked;
	int         mismatches;
	int         idle_cycles;
	int         burst_left;
	bit         gaps_on;
	rx_mode_t   rx_mode;
	bit         hold_start;
	int         hold_left;
	int         stall_run;

	json_string_escaper i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw_valid (raw_valid),
		.raw_stall (raw_stall),
		.raw       (raw),
		.esc_valid (esc_valid),
		.esc_stall (esc_stall),
		.esc       (esc)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [7:0] nibble_char(input logic [3:0] v);
		if (v < 4'd10)
			return CH_ZERO + {4'h0, v};
		return CH_LOWER_A + {4'h0, v} - 8'd10;
	endfunction

	function void put_char(input logic [7:0] b, input logic done);
		out_item_t r;
		r.out_byte    = b;
		r.run_last    = 1'b0;
		r.string_done = done;
		item_text.push_back(r);
	endfunction

	function void put_short_escape(input logic [7:0] b);
		put_char(CH_BSL, 1'b0);
		put_char(b, 1'b0);
	endfunction

	function void escape_plain(input logic [7:0] b);
		case (b)
			CH_BSL:   put_short_escape(CH_BSL);
			CH_QUOTE: put_short_escape(CH_QUOTE);
			CH_BS:    put_short_escape(CH_B);
			CH_FF:    put_short_escape(CH_F);
			CH_LF:    put_short_escape(CH_N);
			CH_CR:    put_short_escape(CH_R);
			CH_TAB:   put_short_escape(CH_T);
			default: begin
				if (b <= CTRL_MAX) begin
					put_short_escape(CH_U);
					put_char(CH_ZERO, 1'b0);
					put_char(CH_ZERO, 1'b0);
					put_char(nibble_char(b[7:4]), 1'b0);
					put_char(nibble_char(b[3:0]), 1'b0);
				end else if (b == LS_LEAD) begin
					held_count = 2'd1;
				end else begin
					put_char(b, 1'b0);
				end
			end
		endcase
	endfunction

	function void flush_prefix();
		if (held_count >= 2'd1)
			put_char(LS_LEAD, 1'b0);
		if (held_count >= 2'd2)
			put_char(LS_MID, 1'b0);
		held_count = 2'd0;
	endfunction

	function void predict_escape(input in_item_t it);
		item_text.delete();
		if (!in_string) begin
			put_char(CH_QUOTE, 1'b0);
			in_string = 1'b1;
		end
		if (it.op == OP_END) begin
			flush_prefix();
			put_char(CH_QUOTE, 1'b1);
			in_string = 1'b0;
		end else if (held_count == 2'd0) begin
			escape_plain(it.data_byte);
		end else if (held_count == 2'd1) begin
			if (it.data_byte == LS_MID) begin
				held_count = 2'd2;
			end else begin
				flush_prefix();
				escape_plain(it.data_byte);
			end
		end else if (it.data_byte == LS_2028 || it.data_byte == LS_2029) begin
			put_short_escape(CH_U);
			put_char(CH_TWO, 1'b0);
			put_char(CH_ZERO, 1'b0);
			put_char(CH_TWO, 1'b0);
			put_char(it.data_byte == LS_2028 ? CH_EIGHT : CH_NINE, 1'b0);
			held_count = 2'd0;
		end else begin
			flush_prefix();
			escape_plain(it.data_byte);
		end
		if (item_text.size() > 0)
			item_text[item_text.size()-1].run_last = 1'b1;
		foreach (item_text[k])
			expected_text.push_back(item_text[k]);
	endfunction

	// ---------------------------------------------------------------- checker

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && esc_valid && !esc_stall) begin
			bytes_checked++;
			if (expected_text.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$error("unexpected output item: out_byte %h", esc.out_byte);
			end else begin
				want = expected_text.pop_front();
				if (esc.out_byte !== want.out_byte) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$error("out_byte: expected %h, got %h", want.out_byte, esc.out_byte);
				end
				if (esc.run_last !== want.run_last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$error("run_last: expected %b, got %b", want.run_last, esc.run_last);
				end
				if (esc.string_done !== want.string_done) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$error("string_done: expected %b, got %b",
							want.string_done, esc.string_done);
				end
			end
		end
	end

	// nothing accepted on either side for too long means the block has hung
	always @(posedge clk) begin
		if (!arst_n || (raw_valid && !raw_stall) || (esc_valid && !esc_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("timeout: %0d cycles without a handshake", IDLE_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	always @(negedge clk) begin
		if (hold_start) begin
			hold_left  = HOLD_CYCLES;
			hold_start = 1'b0;
		end
		if (hold_left != 0) begin
			esc_stall = 1'b1;
			hold_left--;
		end else if (rx_mode == RX_FREE) begin
			esc_stall = 1'b0;
		end else if (stall_run != 0) begin
			stall_run--;
		end else begin
			esc_stall = !esc_stall;
			if (esc_stall)
				stall_run = rx_mode == RX_HEAVY ? $urandom_range(1, 12) : $urandom_range(0, 4);
			else
				stall_run = rx_mode == RX_HEAVY ? $urandom_range(0, 3) : $urandom_range(0, 10);
		end
	end

	// ---------------------------------------------------------------- sender

	task automatic tx_gap(input int cycles);
		@(negedge clk);
		raw_valid = 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic send_item(input op_t op, input logic [7:0] b);
		in_item_t it;
		it.op        = op;
		it.data_byte = b;
		@(negedge clk);
		raw_valid = 1'b1;
		raw       = it;
		do @(posedge clk); while (raw_stall);
		predict_escape(it);
		items_sent++;
		if (op == OP_END)
			strings_sent++;
	endtask

	task automatic pace();
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (gaps_on)
				tx_gap($urandom_range(1, 8));
		end
		burst_left--;
	endtask

	task automatic send_byte(input logic [7:0] b);
		pace();
		send_item(OP_BYTE, b);
	endtask

	task automatic send_end();
		pace();
		send_item(OP_END, 8'($urandom_range(0, 255)));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		raw_valid = 1'b0;
		while (expected_text.size() != 0) @(posedge clk);
	endtask

	// one chunk of string content, weighted towards separators and escapes
	task automatic send_fragment();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0: begin
				send_byte(LS_LEAD);
				send_byte(LS_MID);
				send_byte($urandom_range(0, 1) ? LS_2029 : LS_2028);
			end
			1: begin
				send_byte(LS_LEAD);
				send_byte(LS_MID);
				send_byte(8'($urandom_range(0, 255)));
			end
			2: begin
				send_byte(LS_LEAD);
				send_byte(8'($urandom_range(0, 255)));
			end
			3, 4: begin
				if ($urandom_range(0, 2) != 0)
					send_byte(8'($urandom_range(0, 31)));
				else
					send_byte($urandom_range(0, 1) ? CH_BSL : CH_QUOTE);
			end
			default: send_byte(8'($urandom_range(0, 255)));
		endcase
	endtask

	task automatic send_random_string(input int max_len);
		int n;
		n = $urandom_range(0, max_len);
		while (n > 0) begin
			send_fragment();
			n--;
		end
		send_end();
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_empty_string();
		send_end();
	endtask

	task automatic test_escape_table();
		logic [7:0] chars[10];
		chars = '{8'h00, CTRL_MAX, 8'hff, CH_BSL, CH_QUOTE, CH_BS, CH_FF, CH_LF, CH_CR, CH_TAB};
		foreach (chars[k])
			send_byte(chars[k]);
		send_end();
	endtask

	// both separators, a lead byte restarting the hold, a broken two-byte
	// prefix, and end of string with one and two bytes held
	task automatic test_line_separators();
		logic [7:0] seq[12];
		seq = '{LS_LEAD, LS_MID, LS_2028, LS_LEAD, LS_MID, LS_2029,
			LS_LEAD, LS_LEAD, LS_MID, CH_QUOTE, LS_LEAD, LS_MID};
		foreach (seq[k])
			send_byte(seq[k]);
		send_end();
		send_byte(LS_LEAD);
		send_end();
	endtask

	// receiver holds off while the sender keeps pushing control-character escapes
	task automatic test_backpressure();
		wait_drained();
		gaps_on    = 1'b0;
		hold_start = 1'b1;
		repeat (39)
			send_byte(8'($urandom_range(0, 31)));
		send_end();
		wait_drained();
	endtask

	task automatic test_random_strings();
		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 7) == 0) begin
				gaps_on = $urandom_range(0, 3) != 0;
				rx_mode = rx_mode_t'($urandom_range(0, 2));
			end
			if ($urandom_range(0, 15) == 0)
				wait_drained();
			send_random_string($urandom_range(0, 19) == 0 ? 40 : 10);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		raw_valid     = 1'b0;
		raw           = '0;
		esc_stall     = 1'b0;
		in_string     = 1'b0;
		held_count    = 2'd0;
		items_sent    = 0;
		strings_sent  = 0;
		bytes_checked = 0;
		mismatches    = 0;
		idle_cycles   = 0;
		burst_left    = 0;
		gaps_on       = 1'b1;
		rx_mode       = RX_CHOPPY;
		hold_start    = 1'b0;
		hold_left     = 0;
		stall_run     = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_empty_string();
		test_escape_table();
		test_line_separators();
		test_backpressure();
		gaps_on = 1'b1;
		rx_mode = RX_CHOPPY;
		test_random_strings();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d items in %0d strings (escapes, separators, held prefixes, stalls).",
			items_sent, strings_sent);
		$display("Checked %0d output bytes, %0d mismatches.", bytes_checked, mismatches);
		if (mismatches == 0 && expected_text.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
